FILE: src/nested_length_prefix_framer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nested length-prefix framer
// Shorthand for clocked implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef NESTED_LENGTH_PREFIX_FRAMER_TOP_MACROS_SVH
`define NESTED_LENGTH_PREFIX_FRAMER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NLPF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NLPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/nlpf_pkg.sv
// ----------------------------------------------------------------------------
// Nested length-prefix framer package
// Shared widths, constants, command codes and channel payload types.
// ----------------------------------------------------------------------------
package nlpf_pkg;

    localparam int ADDR_W        = 12;
    localparam int FILL_W        = 13;
    localparam int VIEW_W        = 13;
    localparam int PREFIX_BYTES  = 4;
    localparam int MAX_VIEW      = 4096;
    localparam int BUF_DEPTH_DEF = 4096;
    localparam logic [VIEW_W-1:0] VIEW_RESET = VIEW_W'(4096);

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_END    = 2'd2
    } command_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic              status;
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_byte;
        logic              last;
    } result_t;

    typedef logic [VIEW_W-1:0] view_t;

endpackage

FILE: src/nlpf_chan_if.sv
// ----------------------------------------------------------------------------
// Framer channel interface
// Valid/ready channel with a typed payload; a transaction completes when
// valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface nlpf_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/nested_length_prefix_framer_top.sv
// ----------------------------------------------------------------------------
// Nested length-prefix framer, top level
// Builds nested length-prefixed objects in an on-chip byte buffer and reports
// every stored byte as one result transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries one command. An append stores one byte and
// yields one result. A begin reserves four bytes holding the offset of the
// enclosing object (little-endian) and an end overwrites the open object's
// reservation with its body length (big-endian) and reopens the enclosing
// object; each yields four results, one byte per cycle while the result side
// is ready, through the single write port of the buffer memory. An end that
// finds no open object writes the total message length at offset 0. An item
// that does not fit in the usable space (the space limit register, capped by
// the buffer depth and by 4096) yields one result with status set and changes
// nothing; an unknown command yields one empty result. A new input
// transaction is taken in the same cycle as the last result of the current
// one is loaded into the output register, so with the result side always
// ready the block sustains one append per cycle, while a begin or end holds
// off the next transaction until its fourth result is loaded. The end command
// reads the saved link through the memory's read port in the same cycles as
// it writes the length back, so no separate read step is needed. The buffer
// needs no clearing pass after reset; it is ready at once. The space limit
// may only be written while no transaction is in flight.
`include "nested_length_prefix_framer_top_macros.svh"

module nested_length_prefix_framer_top
    import nlpf_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    nlpf_chan_if.sink   cfg,
    nlpf_chan_if.sink   item,
    nlpf_chan_if.source result
);

    // Index width of the buffer memory and the usable-space cap it implies.
    localparam int IDX_W = $clog2(BUF_DEPTH);
    localparam logic [VIEW_W-1:0] LIMIT_CAP =
        (BUF_DEPTH < MAX_VIEW) ? VIEW_W'(BUF_DEPTH) : VIEW_W'(MAX_VIEW);

    // Buffer memory: one write and one registered read per cycle.
    logic [7:0] buf_mem [BUF_DEPTH];

    // Configuration and framing state.
    logic [VIEW_W-1:0] view_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [ADDR_W-1:0] open_reg, open_next;

    // Command sequencer.
    logic              busy_reg, busy_next;
    logic [1:0]        cmd_reg;
    logic [7:0]        data_reg;
    logic [1:0]        step_reg, step_next;
    logic [7:0]        link_lo_reg, link_lo_next;

    // Memory read side.
    logic [7:0]        rdata_reg;
    logic              rd_ok_reg;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    // Step datapath.
    logic              adv, fire, item_take;
    logic [VIEW_W-1:0] limit;
    logic              room_begin, room_append;
    logic [14:0]       len_diff;
    logic [31:0]       end_len;
    logic [31:0]       open_word;
    logic [1:0]        step_rev;
    logic [ADDR_W-1:0] acc_addr;
    logic              acc_we, acc_re, acc_in_range;
    logic [7:0]        acc_byte;
    result_t           res;
    logic [ADDR_W-1:0] link_full;

    // The output register can take a new result when it is empty or drained.
    assign adv       = !out_valid_reg || result.ready;
    assign fire      = busy_reg && adv;
    assign item_take = item.valid && item.ready;

    assign item.ready     = !busy_reg || (fire && res.last);
    assign cfg.ready      = 1'b1;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    assign limit       = (view_reg > LIMIT_CAP) ? LIMIT_CAP : view_reg;
    assign room_begin  = ({1'b0, fill_reg} + 14'd4) <= {1'b0, limit};
    assign room_append = ({1'b0, fill_reg} + 14'd1) <= {1'b0, limit};

    // Object body length, taken modulo 2^32 like a 32-bit difference.
    assign len_diff  = {2'b00, fill_reg} - {3'b000, open_reg} - 15'd4;
    assign end_len   = {{17{len_diff[14]}}, len_diff};
    assign open_word = {20'd0, open_reg};
    assign step_rev  = ~step_reg;

    assign acc_in_range = int'(acc_addr) < BUF_DEPTH;

    // The link only needs its low 12 bits: byte 0 and the low half of byte 1.
    assign link_full = {(rd_ok_reg ? rdata_reg[3:0] : 4'd0), link_lo_reg};

    // Result and buffer access for the current step of the current command.
    always_comb
    begin
        res      = '0;
        acc_addr = '0;
        acc_byte = '0;
        acc_we   = 1'b0;
        acc_re   = 1'b0;
        case (cmd_reg)
            CMD_BEGIN:
            begin
                if (!room_begin)
                begin
                    res.status = 1'b1;
                    res.last   = 1'b1;
                end
                else
                begin
                    acc_addr = fill_reg[ADDR_W-1:0] + {10'd0, step_reg};
                    acc_byte = open_word[8*step_reg +: 8];
                    acc_we   = 1'b1;
                    res.last = (step_reg == 2'd3);
                end
            end
            CMD_APPEND:
            begin
                res.last = 1'b1;
                if (!room_append)
                begin
                    res.status = 1'b1;
                end
                else
                begin
                    acc_addr = fill_reg[ADDR_W-1:0];
                    acc_byte = data_reg;
                    acc_we   = 1'b1;
                end
            end
            CMD_END:
            begin
                acc_addr = open_reg + {10'd0, step_reg};
                acc_byte = end_len[8*step_rev +: 8];
                acc_we   = 1'b1;
                acc_re   = (step_reg == 2'd0) || (step_reg == 2'd1);
                res.last = (step_reg == 2'd3);
            end
            default:
            begin
                res.last = 1'b1;
            end
        endcase
        if (acc_we)
        begin
            res.write_valid   = 1'b1;
            res.write_address = acc_addr;
            res.write_byte    = acc_byte;
        end
    end

    // Next-state logic of the sequencer and the framing state.
    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        fill_next      = fill_reg;
        open_next      = open_reg;
        link_lo_next   = link_lo_reg;
        out_valid_next = out_valid_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (fire)
        begin
            out_valid_next = 1'b1;
            step_next      = res.last ? 2'd0 : step_reg + 2'd1;
            if (res.last)
            begin
                busy_next = 1'b0;
            end

            // Byte 0 of the saved link arrives one step after it was read.
            if (cmd_reg == CMD_END && step_reg == 2'd1)
            begin
                link_lo_next = rd_ok_reg ? rdata_reg : 8'd0;
            end

            if (res.last && !res.status)
            begin
                if (cmd_reg == CMD_BEGIN)
                begin
                    open_next = fill_reg[ADDR_W-1:0];
                    fill_next = fill_reg + FILL_W'(PREFIX_BYTES);
                end
                else if (cmd_reg == CMD_APPEND)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                else if (cmd_reg == CMD_END)
                begin
                    open_next = (open_reg == '0) ? '0 : link_full;
                end
            end
        end

        if (item_take)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_reg      <= VIEW_RESET;
            fill_reg      <= FILL_W'(PREFIX_BYTES);
            open_reg      <= '0;
            busy_reg      <= 1'b0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                view_reg <= cfg.payload;
            end
            fill_reg      <= fill_next;
            open_reg      <= open_next;
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        link_lo_reg <= link_lo_next;
        if (item_take)
        begin
            cmd_reg  <= item.payload.command;
            data_reg <= item.payload.data_byte;
        end
        if (fire)
        begin
            out_reg <= res;
        end
    end

    // Buffer memory. A read at the address being written returns the old
    // byte, which is how an end picks up its link while writing its length.
    always_ff @(posedge clk)
    begin
        if (fire && acc_we && acc_in_range)
        begin
            buf_mem[IDX_W'(acc_addr)] <= acc_byte;
        end
        if (fire && acc_re)
        begin
            rdata_reg <= buf_mem[IDX_W'(acc_addr)];
            rd_ok_reg <= acc_in_range;
        end
    end

    // An accepted transaction always occupies the sequencer in the next cycle.
    `NLPF_ASSERT_NEXT(a_take_busy, clk, rst_n, item_take, busy_reg,
        "accepted transaction did not start the sequencer")

    // Only begin and end run past their first step.
    `NLPF_ASSERT_SAME(a_multi_step, clk, rst_n, busy_reg && step_reg != 2'd0,
        cmd_reg == CMD_BEGIN || cmd_reg == CMD_END,
        "multi-step sequence on a single-step command")

    // The open object always lies below the fill offset.
    `NLPF_ASSERT_SAME(a_open_below_fill, clk, rst_n, 1'b1,
        {1'b0, open_reg} < fill_reg,
        "open object offset not below fill offset")

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Nested length-prefix framer testbench
// Drives begin, append, end and unknown commands with random idle cycles on
// both channels. A scoreboard predicts every buffer write and compares each
// result transaction against it, field by field, across several view sizes.
// ----------------------------------------------------------------------------
module tb
    import nlpf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Code 3 is not a defined command; the block must answer it with one
    // empty result and leave its state alone.
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // Long enough for the work of a begin or end and for the output
    // register to settle before a configuration write or the final verdict.
    localparam int SETTLE_CYCLES = 12;

    // Watchdog limit for the whole run.
    localparam int CYCLE_LIMIT = 400000;

    localparam int RANDOM_PHASES     = 5;
    localparam int ITEMS_PER_PHASE   = 81;
    localparam int MAX_NEST_DEPTH    = 6;

    logic clk;
    logic rst_n;

    nlpf_chan_if #(.payload_t(view_t))   cfg_if ();
    nlpf_chan_if #(.payload_t(item_t))   item_if ();
    nlpf_chan_if #(.payload_t(result_t)) result_if ();

    nested_length_prefix_framer_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if.sink),
        .item   (item_if.sink),
        .result (result_if.source)
    );

    // ------------------------------------------------------------------------
    // Mirror of the framer state. The buffer copy is what lets an end
    // recover the enclosing object's offset exactly as the hardware does.
    // ------------------------------------------------------------------------
    logic [7:0]        shadow_buf [BUF_DEPTH_DEF];
    logic [FILL_W-1:0] fill_ptr;
    logic [ADDR_W-1:0] open_obj;
    view_t             view_reg;
    int                obj_depth;

    // Buffer writes (and error or empty results) still owed by the block.
    result_t expected_writes [$];
    int      failures;

    // Idle modes for each side; toggled during the random part so that
    // long stretches without any idling are mixed with busy stretches.
    bit src_pause_on;
    bit sink_pause_on;

    // ------------------------------------------------------------------------
    // Clock and reset. Reset is applied once and then released.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. If the run hangs, report failure and stop.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction helpers.
    // ------------------------------------------------------------------------
    function automatic result_t make_result(logic st, logic wv, logic [ADDR_W-1:0] addr,
                                            logic [7:0] data, logic fin);
        result_t r;
        r.status        = st;
        r.write_valid   = wv;
        r.write_address = addr;
        r.write_byte    = data;
        r.last          = fin;
        return r;
    endfunction

    // Store one byte in the mirror and queue the write the block must report.
    function automatic void record_write(int unsigned addr, logic [7:0] data, logic fin);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(addr);
        shadow_buf[a] = data;
        expected_writes.push_back(make_result(1'b0, 1'b1, a, data, fin));
    endfunction

    // Work out the results of one command and advance the mirrored state.
    function automatic void predict_writes(logic [1:0] cmd, logic [7:0] data);
        int unsigned       limit;
        int unsigned       fill;
        int unsigned       outer;
        logic [ADDR_W-1:0] base;
        logic [31:0]       span;
        logic [31:0]       link;
        limit = view_reg;
        if (limit > BUF_DEPTH_DEF)
            limit = BUF_DEPTH_DEF;
        if (limit > MAX_VIEW)
            limit = MAX_VIEW;
        fill  = fill_ptr;
        outer = open_obj;
        case (cmd)
            CMD_BEGIN:
            begin
                if (fill + PREFIX_BYTES > limit)
                begin
                    expected_writes.push_back(make_result(1'b1, 1'b0, '0, '0, 1'b1));
                end
                else
                begin
                    // The reservation holds the enclosing object's offset,
                    // least significant byte first.
                    for (int k = 0; k < PREFIX_BYTES; k++)
                        record_write(fill + k, 8'(outer >> (8 * k)), k == PREFIX_BYTES - 1);
                    open_obj  = fill_ptr[ADDR_W-1:0];
                    fill_ptr  = FILL_W'(fill + PREFIX_BYTES);
                    obj_depth++;
                end
            end
            CMD_APPEND:
            begin
                if (fill + 1 > limit)
                    expected_writes.push_back(make_result(1'b1, 1'b0, '0, '0, 1'b1));
                else
                begin
                    record_write(fill, data, 1'b1);
                    fill_ptr = FILL_W'(fill + 1);
                end
            end
            CMD_END:
            begin
                // With nothing open the base is 0: the total length goes
                // into the prefix and the link is taken as 0.
                base = open_obj;
                span = 32'(fill) - 32'(base) - PREFIX_BYTES;
                link = '0;
                if (base != '0)
                begin
                    for (int k = 0; k < PREFIX_BYTES; k++)
                        link |= 32'(shadow_buf[ADDR_W'(base + k)]) << (8 * k);
                end
                // The length goes back most significant byte first.
                for (int k = 0; k < PREFIX_BYTES; k++)
                    record_write(base + k, 8'(span >> (8 * (PREFIX_BYTES - 1 - k))),
                                 k == PREFIX_BYTES - 1);
                open_obj = link[ADDR_W-1:0];
                if (base != '0)
                    obj_depth--;
            end
            default:
            begin
                expected_writes.push_back(make_result(1'b0, 1'b0, '0, '0, 1'b1));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Command sender. Each call predicts the command's results, waits its
    // idle cycles with valid low, then holds the transaction until it is
    // taken. Valid stays high when the next command follows at once.
    // ------------------------------------------------------------------------
    task automatic send_command(input logic [1:0] cmd, input logic [7:0] data);
        int    gap;
        item_t it;
        gap = src_pause_on ? $urandom_range(0, 6) : 0;
        predict_writes(cmd, data);
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.command     = cmd;
        it.data_byte   = data;
        item_if.payload <= it;
        item_if.valid   <= 1'b1;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every owed result has been seen, then let
    // the block settle so that it is fully idle.
    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the space limit register. Only called while the block is idle.
    task automatic write_space_limit(input view_t value);
        cfg_if.payload <= value;
        cfg_if.valid   <= 1'b1;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        view_reg = value;
    endtask

    // ------------------------------------------------------------------------
    // Result side. Ready is dropped for a random number of cycles after each
    // transaction while the sink idle mode is on.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        stall = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
                stall = sink_pause_on ? $urandom_range(0, 6) : 0;
            if (!rst_n)
                result_if.ready <= 1'b0;
            else if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                stall--;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard. Every result transaction is matched to the oldest owed
    // result; each field is compared on its own.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : write_checker
        result_t want;
        result_t got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = result_if.payload;
            if (expected_writes.size() == 0)
            begin
                $error("unexpected result: status=%0d valid=%0d address=%0d byte=%0d last=%0d",
                       got.status, got.write_valid, got.write_address, got.write_byte,
                       got.last);
                failures++;
            end
            else
            begin
                want = expected_writes.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    failures++;
                end
                if (got.write_valid !== want.write_valid)
                begin
                    $error("write_valid: expected %0d, got %0d",
                           want.write_valid, got.write_valid);
                    failures++;
                end
                if (got.write_address !== want.write_address)
                begin
                    $error("write_address: expected %0d, got %0d",
                           want.write_address, got.write_address);
                    failures++;
                end
                if (got.write_byte !== want.write_byte)
                begin
                    $error("write_byte: expected 0x%02h, got 0x%02h",
                           want.write_byte, got.write_byte);
                    failures++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Every command once under the reset view size, with data extremes, a
    // top-level end that writes the total length, and an unknown command.
    task automatic test_basic_commands();
        src_pause_on  <= 1'b0;
        sink_pause_on <= 1'b0;
        send_command(CMD_BEGIN, 8'h00);
        send_command(CMD_APPEND, 8'h00);
        send_command(CMD_APPEND, 8'hFF);
        send_command(CMD_END, 8'hFF);
        send_command(CMD_END, 8'h00);
        send_command(CMD_UNKNOWN, 8'hA5);
    endtask

    // Objects inside objects: each end must pop to the enclosing offset that
    // its begin saved, with both channels idling at random.
    task automatic test_nesting_links();
        src_pause_on  <= 1'b1;
        sink_pause_on <= 1'b1;
        send_command(CMD_BEGIN, 8'h5A);
        send_command(CMD_BEGIN, 8'hC3);
        send_command(CMD_APPEND, 8'h81);
        send_command(CMD_END, 8'h00);
        send_command(CMD_APPEND, 8'h7E);
        send_command(CMD_END, 8'h00);
        send_command(CMD_END, 8'h00);
        wait_drained();
    endtask

    // Out-of-space errors at the exact boundaries, the smallest and a
    // below-minimum view size, and a value above the 4096 cap.
    task automatic test_space_limits();
        src_pause_on  <= 1'b0;
        sink_pause_on <= 1'b1;
        // No room at all: begin and append fail, end still works.
        write_space_limit(view_t'(fill_ptr));
        send_command(CMD_BEGIN, 8'h11);
        send_command(CMD_APPEND, 8'h22);
        send_command(CMD_END, 8'h33);
        wait_drained();
        // Room for exactly one byte.
        write_space_limit(view_t'(fill_ptr + 1));
        send_command(CMD_APPEND, 8'h44);
        send_command(CMD_APPEND, 8'h55);
        wait_drained();
        // Room for exactly one reservation; the end ignores the limit.
        write_space_limit(view_t'(fill_ptr + PREFIX_BYTES));
        send_command(CMD_BEGIN, 8'h66);
        send_command(CMD_APPEND, 8'h77);
        send_command(CMD_END, 8'h88);
        wait_drained();
        write_space_limit(view_t'(PREFIX_BYTES));
        send_command(CMD_BEGIN, 8'h99);
        send_command(CMD_APPEND, 8'hAA);
        wait_drained();
        write_space_limit(view_t'(2));
        send_command(CMD_APPEND, 8'hBB);
        wait_drained();
        // All ones: capped to the buffer, so this behaves like 4096.
        write_space_limit('1);
        send_command(CMD_BEGIN, 8'hCC);
        send_command(CMD_END, 8'hDD);
        wait_drained();
        write_space_limit(VIEW_RESET);
    endtask

    // ------------------------------------------------------------------------
    // Random framing. Mostly well-formed nesting with random content, plus
    // unknown commands and stray commands. Each phase writes its own view
    // size, some tight enough that space runs out part way through.
    // ------------------------------------------------------------------------
    task automatic test_random_framing();
        int         pick;
        logic [1:0] cmd;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: write_space_limit(VIEW_RESET);
                1: write_space_limit(view_t'(fill_ptr + $urandom_range(0, 40)));
                2: write_space_limit(view_t'($urandom_range(MAX_VIEW, fill_ptr + 8)));
                3: write_space_limit(view_t'($urandom_range(MAX_VIEW + 1, 8191)));
                default: write_space_limit(view_t'(fill_ptr + $urandom_range(0, 12)));
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 23) == 0)
                    src_pause_on <= !src_pause_on;
                if ($urandom_range(0, 23) == 0)
                    sink_pause_on <= !sink_pause_on;
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    cmd = CMD_UNKNOWN;
                else if (pick < 12)
                    cmd = 2'($urandom_range(0, 3));
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (obj_depth == 0)
                        cmd = (pick < 55) ? CMD_BEGIN : (pick < 90) ? CMD_APPEND : CMD_END;
                    else if (pick < 20 && obj_depth < MAX_NEST_DEPTH)
                        cmd = CMD_BEGIN;
                    else if (pick < 70)
                        cmd = CMD_APPEND;
                    else
                        cmd = CMD_END;
                end
                send_command(cmd, 8'($urandom_range(0, 255)));
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        failures  = 0;
        fill_ptr  = FILL_W'(PREFIX_BYTES);
        open_obj  = '0;
        view_reg  = VIEW_RESET;
        obj_depth = 0;
        src_pause_on  <= 1'b0;
        sink_pause_on <= 1'b0;
        cfg_if.valid    <= 1'b0;
        cfg_if.payload  <= VIEW_RESET;
        item_if.valid   <= 1'b0;
        item_if.payload <= '0;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_commands();
        test_nesting_links();
        test_space_limits();
        test_random_framing();
        wait_drained();

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/nlpf_pkg.sv
src/nlpf_chan_if.sv
src/nested_length_prefix_framer_top.sv
bench/tb.sv
